// ----- design/hhsw_pkg.sv -----
// ----------------------------------------------------------------------------
// hhsw_pkg
// Shared constants and types for the header strip / soft wrap block.
// ----------------------------------------------------------------------------
package hhsw_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned COL_W  = 10;

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   // what one processed item hands to the output stage
   typedef struct packed {
      logic              emit;     // item yields at least one byte
      logic [BYTE_W-1:0] data;     // first byte
      logic              add_lf;   // a line feed follows the first byte
   } result_type;

endpackage

// ----- design/hhsw_parse.sv -----
// ----------------------------------------------------------------------------
// hhsw_parse
// Header detection window, header flag and column counter. Produces the
// result of the registered item combinationally; state advances on fire.
// ----------------------------------------------------------------------------
module hhsw_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [hhsw_pkg::BYTE_W-1:0]      in_byte,
   input  logic                             new_stream,
   input  logic [hhsw_pkg::COL_W-1:0]       wrap_columns,
   output hhsw_pkg::result_type             result
);

   logic [hhsw_pkg::BYTE_W-1:0] recent0_ff, recent1_ff, recent2_ff;
   logic [hhsw_pkg::BYTE_W-1:0] recent0_in, recent1_in, recent2_in;
   logic                        hdr_done_ff, hdr_done_in;
   logic [hhsw_pkg::COL_W-1:0]  column_ff, column_in;

   logic [hhsw_pkg::BYTE_W-1:0] r0, r1, r2;
   logic                        hdr;
   logic [hhsw_pkg::COL_W-1:0]  col, col_inc;
   logic                        hdr_end;

   always_comb begin
      // new stream clears state ahead of this byte
      r0      = new_stream ? '0 : recent0_ff;
      r1      = new_stream ? '0 : recent1_ff;
      r2      = new_stream ? '0 : recent2_ff;
      hdr     = new_stream ? 1'b0 : hdr_done_ff;
      col     = new_stream ? '0 : column_ff;
      col_inc = col + {{(hhsw_pkg::COL_W-1){1'b0}}, 1'b1};

      hdr_end = (in_byte == hhsw_pkg::CH_LF) &&
                ((r2 == hhsw_pkg::CH_LF) ||
                 (r0 == hhsw_pkg::CH_CR && r1 == hhsw_pkg::CH_LF &&
                  r2 == hhsw_pkg::CH_CR));

      recent0_in  = r0;
      recent1_in  = r1;
      recent2_in  = r2;
      hdr_done_in = hdr;
      column_in   = col;

      result.emit   = 1'b0;
      result.data   = in_byte;
      result.add_lf = 1'b0;

      if (!hdr) begin
         // drop header bytes, shift the window
         recent0_in = r1;
         recent1_in = r2;
         recent2_in = in_byte;
         if (hdr_end) begin
            hdr_done_in = 1'b1;
            column_in   = '0;
         end
      end else if (wrap_columns == '0) begin
         result.emit = 1'b1;
      end else if (in_byte == hhsw_pkg::CH_CR) begin
         column_in = '0;
      end else if (in_byte == hhsw_pkg::CH_LF) begin
         column_in   = '0;
         result.emit = 1'b1;
      end else begin
         result.emit = 1'b1;
         if (col_inc >= wrap_columns) begin
            column_in     = '0;
            result.add_lf = 1'b1;
         end else begin
            column_in = col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent0_ff  <= '0;
         recent1_ff  <= '0;
         recent2_ff  <= '0;
         hdr_done_ff <= 1'b0;
         column_ff   <= '0;
      end else if (fire) begin
         recent0_ff  <= recent0_in;
         recent1_ff  <= recent1_in;
         recent2_ff  <= recent2_in;
         hdr_done_ff <= hdr_done_in;
         column_ff   <= column_in;
      end
   end

endmodule

// ----- design/hhsw_out.sv -----
// ----------------------------------------------------------------------------
// hhsw_out
// Result register. Holds one byte and a pending inserted line feed, which
// goes out in the cycle after the byte is taken.
// ----------------------------------------------------------------------------
module hhsw_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  hhsw_pkg::result_type         result,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hhsw_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_last
);

   logic                        valid_ff, valid_in;
   logic                        lf_pend_ff, lf_pend_in;
   logic [hhsw_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        last_ff, last_in;

   assign out_free = !valid_ff || (!rsp_stall && !lf_pend_ff);

   always_comb begin
      valid_in   = valid_ff;
      lf_pend_in = lf_pend_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      if (load) begin
         valid_in   = 1'b1;
         byte_in    = result.data;
         last_in    = !result.add_lf;
         lf_pend_in = result.add_lf;
      end else if (valid_ff && !rsp_stall) begin
         if (lf_pend_ff) begin
            // advance to the inserted line feed
            byte_in    = hhsw_pkg::CH_LF;
            last_in    = 1'b1;
            lf_pend_in = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         lf_pend_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         lf_pend_ff <= lf_pend_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- design/http_header_strip_soft_wrap.sv -----
// ----------------------------------------------------------------------------
// http_header_strip_soft_wrap
// Strips the HTTP header from a response byte stream, passes the body and
// optionally soft-wraps it at a programmable column.
// ----------------------------------------------------------------------------
// Bytes are taken into an input register, processed in one pass and placed
// in a result register. One byte is accepted per cycle when it yields no
// output byte, or one output byte while rsp_stall is low; a byte that
// triggers an inserted line feed holds the result register until the line
// feed is taken too, since that register hands out one byte per cycle while
// rsp_stall is low. Header bytes and removed CRs give no output. rsp_last
// marks the final byte caused by an input. Write csr_write_data (wrap width,
// zero disables wrapping and CR removal) only while the block is idle.
module http_header_strip_soft_wrap (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [hhsw_pkg::COL_W-1:0]   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hhsw_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                         req_new_stream,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hhsw_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_last
);

   logic [hhsw_pkg::COL_W-1:0]  wrap_ff;
   logic                        in_valid_ff, in_valid_in;
   logic [hhsw_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_new_ff;

   hhsw_pkg::result_type        result;
   logic                        out_free;
   logic                        fire;
   logic                        accept;

   // an item that yields nothing leaves regardless of the output side
   assign fire      = in_valid_ff && (!result.emit || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wrap_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            wrap_ff <= csr_write_data;
         end
      end
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_new_ff  <= req_new_stream;
      end
   end

   hhsw_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (in_byte_ff),
      .new_stream   (in_new_ff),
      .wrap_columns (wrap_ff),
      .result       (result)
   );

   hhsw_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (fire && result.emit),
      .result       (result),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
